[rtl/core/pmsp_pkg.sv]
// Shared types and constants for the PLA minterm stream parser.
// Holds the byte and result structs, result kind codes and character codes.
// No dependencies; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package pmsp_pkg;

  // Default width of the .i/.o/.p counters (saturating)
  localparam int COUNT_WIDTH_DEF = 16;

  // Result queue between parser front end and output side
  localparam int QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_CHAR     = 3'd1;
  localparam logic [2:0] KIND_TERM     = 3'd2;
  localparam logic [2:0] KIND_END      = 3'd3;
  localparam logic [2:0] KIND_END_HDR  = 3'd4;
  localparam logic [2:0] KIND_TRUNC    = 3'd5;

  // Character codes
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Terminal value remap: six is reported as five
  localparam logic [7:0] TERM_SIX  = 8'd6;
  localparam logic [7:0] TERM_FIVE = 8'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_stream;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] position;
    logic [7:0]  character;
    logic [7:0]  terminal;
    logic [15:0] input_count;
    logic [15:0] output_count;
    logic [15:0] product_count;
  } result_item_t;

  // Front end to queue: up to two results per accepted byte
  typedef struct packed {
    logic         push0;
    logic         push1;
    result_item_t item0;
    result_item_t item1;
  } push_t;

endpackage

[rtl/core/pmsp_front.sv]
// Parser front end: accepts text bytes, tracks header/body phase and emits results.
// Produces up to two results per byte toward the result queue.
// Depends on pmsp_pkg.
`timescale 1ns / 1ps

module pmsp_front import pmsp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  byte_item_t data,
  output push_t      push
);

  localparam int CW = COUNT_WIDTH;
  localparam int AW = COUNT_WIDTH + 4;
  localparam int EW = COUNT_WIDTH + 16;
  localparam logic [CW-1:0] CountMax = '1;

  // Parser phases
  localparam logic [3:0] PH_HDR_START  = 4'd0;
  localparam logic [3:0] PH_HDR_DOT    = 4'd1;
  localparam logic [3:0] PH_HDR_NUM    = 4'd2;
  localparam logic [3:0] PH_HDR_SKIP   = 4'd3;
  localparam logic [3:0] PH_BODY_START = 4'd4;
  localparam logic [3:0] PH_BODY_SKIP  = 4'd5;
  localparam logic [3:0] PH_BODY_IN    = 4'd6;
  localparam logic [3:0] PH_BODY_OUT   = 4'd7;
  localparam logic [3:0] PH_DONE       = 4'd8;

  // Directive letters
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_I    = 2'd1;
  localparam logic [1:0] DIR_O    = 2'd2;
  localparam logic [1:0] DIR_P    = 2'd3;

  logic [3:0]    phase, phase_next;
  logic [1:0]    directive_letter, directive_letter_next;
  logic [CW-1:0] number_value, number_value_next;
  logic          seen_digit, seen_digit_next;
  logic [CW-1:0] in_bits_count, in_bits_count_next;
  logic [CW-1:0] out_bits_count, out_bits_count_next;
  logic [CW-1:0] products_expected, products_expected_next;
  logic [CW-1:0] char_index, char_index_next;
  logic [7:0]    term_value, term_value_next;
  logic          only_dashes, only_dashes_next;

  logic [7:0]    c;
  logic          is_blank;
  logic          is_digit;
  logic [AW-1:0] acc;
  logic [CW-1:0] idx_inc;
  logic [7:0]    term_out;
  logic [EW-1:0] ext_in, ext_out, ext_prod, ext_idx;

  assign c        = data.text_byte;
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

  // Decimal accumulate: value * 10 + digit
  assign acc = (AW'(number_value) << 3) + (AW'(number_value) << 1) + AW'(c[3:0]);

  assign idx_inc = char_index + CW'(1);

  // Terminal value with all-dash and six-to-five rules
  always_comb begin
    term_out = only_dashes ? 8'd0 : term_value;
    if (term_out == TERM_SIX) begin
      term_out = TERM_FIVE;
    end
  end

  // Fit counts to the 16-bit result fields
  assign ext_in   = EW'(in_bits_count);
  assign ext_out  = EW'(out_bits_count);
  assign ext_prod = EW'(products_expected);
  assign ext_idx  = EW'(char_index);

  // Next-state and result generation
  always_comb begin
    phase_next             = phase;
    directive_letter_next  = directive_letter;
    number_value_next      = number_value;
    seen_digit_next        = seen_digit;
    in_bits_count_next     = in_bits_count;
    out_bits_count_next    = out_bits_count;
    products_expected_next = products_expected;
    char_index_next        = char_index;
    term_value_next        = term_value;
    only_dashes_next       = only_dashes;
    push                   = '0;

    if (accept && (phase != PH_DONE)) begin
      if (data.end_of_stream) begin
        // Close the stream with a status by phase
        push.push0 = 1'b1;
        if (phase <= PH_HDR_SKIP) begin
          push.item0.kind = KIND_END_HDR;
        end else if ((phase == PH_BODY_START) || (phase == PH_BODY_SKIP)) begin
          push.item0.kind = KIND_END;
        end else begin
          push.item0.kind = KIND_TRUNC;
        end
        phase_next = PH_DONE;
      end else begin
        unique case (phase)
          PH_HDR_START: begin
            if (c == CH_HASH) begin
              phase_next = PH_HDR_SKIP;
            end else if (c == CH_DOT) begin
              phase_next = PH_HDR_DOT;
            end else begin
              // End of header: header result, then first line character
              push.push0               = 1'b1;
              push.item0.kind          = KIND_HEADER;
              push.item0.input_count   = ext_in[15:0];
              push.item0.output_count  = ext_out[15:0];
              push.item0.product_count = ext_prod[15:0];
              push.push1               = 1'b1;
              push.item1.kind          = KIND_CHAR;
              push.item1.character     = c;
              term_value_next          = 8'd0;
              only_dashes_next         = 1'b1;
              char_index_next          = CW'(1);
              phase_next = (in_bits_count <= CW'(1)) ? PH_BODY_OUT : PH_BODY_IN;
            end
          end
          PH_HDR_DOT: begin
            number_value_next = '0;
            seen_digit_next   = 1'b0;
            if (c == CH_I) begin
              directive_letter_next = DIR_I;
              phase_next            = PH_HDR_NUM;
            end else if (c == CH_O) begin
              directive_letter_next = DIR_O;
              phase_next            = PH_HDR_NUM;
            end else if (c == CH_P) begin
              directive_letter_next = DIR_P;
              phase_next            = PH_HDR_NUM;
            end else begin
              directive_letter_next = DIR_NONE;
              phase_next = (c == CH_NL) ? PH_HDR_START : PH_HDR_SKIP;
            end
          end
          PH_HDR_NUM: begin
            if (is_digit) begin
              number_value_next = (acc > AW'(CountMax)) ? CountMax : acc[CW-1:0];
              seen_digit_next   = 1'b1;
            end else if (seen_digit || !is_blank) begin
              // Commit the count on digits seen or a bare newline
              if (seen_digit || (c == CH_NL)) begin
                unique case (directive_letter)
                  DIR_I:   in_bits_count_next     = number_value;
                  DIR_O:   out_bits_count_next    = number_value;
                  DIR_P:   products_expected_next = number_value;
                  default: ;
                endcase
              end
              directive_letter_next = DIR_NONE;
              phase_next = (c == CH_NL) ? PH_HDR_START : PH_HDR_SKIP;
            end
          end
          PH_HDR_SKIP: begin
            if (c == CH_NL) begin
              phase_next = PH_HDR_START;
            end
          end
          PH_BODY_START: begin
            if (c == CH_DOT) begin
              phase_next = PH_BODY_SKIP;
            end else begin
              push.push0           = 1'b1;
              push.item0.kind      = KIND_CHAR;
              push.item0.character = c;
              term_value_next      = 8'd0;
              only_dashes_next     = 1'b1;
              char_index_next      = CW'(1);
              phase_next = (in_bits_count <= CW'(1)) ? PH_BODY_OUT : PH_BODY_IN;
            end
          end
          PH_BODY_SKIP: begin
            if (c == CH_NL) begin
              phase_next = PH_BODY_START;
            end
          end
          PH_BODY_IN: begin
            push.push0           = 1'b1;
            push.item0.kind      = KIND_CHAR;
            push.item0.position  = ext_idx[15:0];
            push.item0.character = c;
            char_index_next      = idx_inc;
            if (idx_inc >= in_bits_count) begin
              phase_next = PH_BODY_OUT;
            end
          end
          PH_BODY_OUT: begin
            if (c == CH_NL) begin
              push.push0          = 1'b1;
              push.item0.kind     = KIND_TERM;
              push.item0.terminal = term_out;
              phase_next          = PH_BODY_START;
            end else if (!is_blank) begin
              term_value_next = {term_value[6:0], (c == CH_ONE)};
              if ((c != CH_DASH) && (c != CH_TWO)) begin
                only_dashes_next = 1'b0;
              end
            end
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR_START;
      directive_letter  <= DIR_NONE;
      number_value      <= '0;
      seen_digit        <= 1'b0;
      in_bits_count     <= '0;
      out_bits_count    <= '0;
      products_expected <= '0;
      char_index        <= '0;
      term_value        <= 8'd0;
      only_dashes       <= 1'b1;
    end else begin
      phase             <= phase_next;
      directive_letter  <= directive_letter_next;
      number_value      <= number_value_next;
      seen_digit        <= seen_digit_next;
      in_bits_count     <= in_bits_count_next;
      out_bits_count    <= out_bits_count_next;
      products_expected <= products_expected_next;
      char_index        <= char_index_next;
      term_value        <= term_value_next;
      only_dashes       <= only_dashes_next;
    end
  end

endmodule

[rtl/core/pmsp_queue.sv]
// Result queue: takes up to two results per cycle, delivers one per beat.
// Parts the parser front end from the output handshake.
// Depends on pmsp_pkg.
`timescale 1ns / 1ps

module pmsp_queue import pmsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  push_t        push,
  output logic         full,
  output logic         valid,
  input  logic         stall,
  output result_item_t item
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  result_item_t  entries [QUEUE_DEPTH];
  logic [PW-1:0] head, tail;
  logic [NW-1:0] count, count_next;
  logic          pop;

  assign valid = (count != '0);
  assign item  = entries[head];
  assign pop   = valid && !stall;

  // Leave room for a two-result beat
  assign full = (count > NW'(QUEUE_DEPTH - 2));

  always_comb begin
    count_next = count + NW'(push.push0) + NW'(push.push1) - NW'(pop);
  end

  // Write incoming results at the tail
  always_ff @(posedge clk) begin
    if (push.push0) begin
      entries[tail] <= push.item0;
    end
    if (push.push1) begin
      entries[tail + PW'(1)] <= push.item1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PW'(push.push0) + PW'(push.push1);
      head  <= head + PW'(pop);
      count <= count_next;
    end
  end

endmodule

[rtl/core/pla_minterm_stream_parser_core.sv]
// Top level of the PLA minterm stream parser.
// Instantiates pmsp_front and pmsp_queue; depends on pmsp_pkg.
`timescale 1ns / 1ps

// Parses PLA text one byte per beat and takes a byte every clock cycle as long
// as the four-entry result queue has room for two results; results leave one per
// beat. The byte that ends the header yields two results (header counts, then
// the first character), so that one beat briefly outpaces the output by one
// entry. After the end-of-stream byte the block gives nothing further until
// reset. Counts from .i, .o and .p saturate at 2^COUNT_WIDTH-1 and are
// reported in their low 16 bits.

module pla_minterm_stream_parser_core import pmsp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  byte_item_t   byte_data,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_data
);

  push_t push;
  logic  full;
  logic  accept;

  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  pmsp_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .data   (byte_data),
    .push   (push)
  );

  pmsp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .valid (result_valid),
    .stall (result_stall),
    .item  (result_data)
  );

endmodule

[rtl/core/pmsp_checker.sv]
// Port-level checks on the parser result channel, bound to the top level.
// Depends on pmsp_pkg and pla_minterm_stream_parser_core.
`timescale 1ns / 1ps

module pmsp_checker import pmsp_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         result_valid,
  input logic         result_stall,
  input result_item_t result_data
);

  logic beat;
  logic ended;
  logic hdr_seen;

  assign beat = result_valid && !result_stall;

  // Track delivered end status and header result
  always_ff @(posedge clk) begin
    if (rst) begin
      ended    <= 1'b0;
      hdr_seen <= 1'b0;
    end else if (beat) begin
      if ((result_data.kind == KIND_END) || (result_data.kind == KIND_END_HDR) ||
          (result_data.kind == KIND_TRUNC)) begin
        ended <= 1'b1;
      end
      if (result_data.kind == KIND_HEADER) begin
        hdr_seen <= 1'b1;
      end
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_data))
    else $error("result payload changed while stalled");

  a_silent_after_end: assert property (@(posedge clk) disable iff (rst)
    ended |-> !result_valid)
    else $error("result after end status");

  a_one_header: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_data.kind == KIND_HEADER) |-> !hdr_seen)
    else $error("second header result");

  a_char_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_data.kind == KIND_CHAR) |->
      (result_data.terminal == 8'd0) && (result_data.input_count == 16'd0))
    else $error("character result carries stray fields");

endmodule

bind pla_minterm_stream_parser_core pmsp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_data  (result_data)
);
